// ===== hdl/signed_int_to_decimal_ascii_unit_assert.svh =====
// assertion macros for the signed integer to decimal ascii unit
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, idle during reset
`define SITOA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitoa assertion failed");

// next-cycle implication, sampled on clk, idle during reset
`define SITOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitoa assertion failed");

`else

`define SITOA_ASSERT_IMP(lbl, ante, cons)
`define SITOA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/sitoa_pkg.sv =====
// shared types and constants for the decimal text converter
`timescale 1ns / 1ps

package sitoa_pkg;

    localparam int NUM_POW = 10;
    localparam int MAG_W   = 32;
    localparam int POS_W   = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // powers of ten, wide enough that nine times the top one still fits
    localparam logic [33:0] POW10 [NUM_POW] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [POS_W-1:0] ndig;
    } sitoa_item_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_SIGN,
        BACK_DIGIT
    } sitoa_back_state_t;

endpackage

// ===== hdl/sitoa_front.sv =====
// front end: takes the integer, forms sign, magnitude and digit count
`timescale 1ns / 1ps

module sitoa_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [31:0]       value,
    input  logic                     value_valid,
    output logic                     value_stall,
    output logic                     push,
    output sitoa_pkg::sitoa_item_t   item,
    input  logic                     full
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] value_reg;
    logic        accept;

    assign value_stall = valid_reg & full;
    assign accept      = value_valid & ~value_stall;
    assign push        = valid_reg & ~full;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
    end

    // the most negative value negates to itself, which is right as unsigned
    always_comb
    begin
        item.neg  = value_reg[31];
        item.mag  = value_reg[31] ? (~value_reg + 32'd1) : value_reg;
        item.ndig = sitoa_pkg::POS_W'(1);
        for (int k = 1; k < sitoa_pkg::NUM_POW; k++)
        begin
            if ({2'b00, item.mag} >= sitoa_pkg::POW10[k])
            begin
                item.ndig = sitoa_pkg::POS_W'(k + 1);
            end
        end
    end

endmodule

// ===== hdl/sitoa_queue.sv =====
// short queue of classified requests between front and back
`timescale 1ns / 1ps

module sitoa_queue #(
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sitoa_pkg::sitoa_item_t   wr_item,
    output logic                     full,
    input  logic                     pop,
    output sitoa_pkg::sitoa_item_t   rd_item,
    output logic                     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sitoa_pkg::sitoa_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hdl/sitoa_back.sv =====
// back end: emits sign and digits, one character per cycle unless text_stall holds the output, msd first
`timescale 1ns / 1ps

module sitoa_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sitoa_pkg::sitoa_item_t   item,
    input  logic                     empty,
    output logic                     pop,
    output logic [7:0]               character,
    output logic                     last,
    output logic                     text_valid,
    input  logic                     text_stall
);

    sitoa_pkg::sitoa_back_state_t state_reg;
    sitoa_pkg::sitoa_back_state_t state_next;

    logic [sitoa_pkg::MAG_W-1:0] mag_reg;
    logic [sitoa_pkg::MAG_W-1:0] mag_next;
    logic [sitoa_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic        advance;
    logic        emit;
    logic [7:0]  emit_char;
    logic        emit_last;
    logic [3:0]  digit;
    logic [33:0] sub;

    assign advance    = ~out_valid_reg | ~text_stall;
    assign character  = char_reg;
    assign last       = last_reg;
    assign text_valid = out_valid_reg;

    // digit at the current position: largest d with d * 10^pos <= magnitude
    always_comb
    begin
        digit = 4'd0;
        sub   = 34'd0;
        for (int d = 1; d < 10; d++)
        begin
            if ({2'b00, mag_reg} >= sitoa_pkg::POW10[pos_reg] * 34'(d))
            begin
                digit = 4'(d);
                sub   = sitoa_pkg::POW10[pos_reg] * 34'(d);
            end
        end
        mag_next = mag_reg - sub[sitoa_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitoa_pkg::BACK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = item.neg ? sitoa_pkg::BACK_SIGN : sitoa_pkg::BACK_DIGIT;
                end
            end
            sitoa_pkg::BACK_SIGN:
            begin
                if (advance)
                begin
                    state_next = sitoa_pkg::BACK_DIGIT;
                end
            end
            sitoa_pkg::BACK_DIGIT:
            begin
                if (advance && pos_reg == '0)
                begin
                    state_next = sitoa_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = sitoa_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_char = sitoa_pkg::CHAR_ZERO;
        emit_last = 1'b0;
        case (state_reg)
            sitoa_pkg::BACK_IDLE:
            begin
                pop = ~empty;
            end
            sitoa_pkg::BACK_SIGN:
            begin
                emit      = advance;
                emit_char = sitoa_pkg::CHAR_MINUS;
            end
            sitoa_pkg::BACK_DIGIT:
            begin
                emit      = advance;
                emit_char = sitoa_pkg::CHAR_ZERO + {4'd0, digit};
                emit_last = (pos_reg == '0);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        out_valid_next = advance ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sitoa_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg <= item.mag;
            pos_reg <= item.ndig - sitoa_pkg::POS_W'(1);
        end
        else if (emit && state_reg == sitoa_pkg::BACK_DIGIT)
        begin
            mag_reg <= mag_next;
            pos_reg <= pos_reg - sitoa_pkg::POS_W'(1);
        end
        if (emit)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

endmodule

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// top level: signed 32-bit integer to decimal ascii text
//
//   channel | ports                                   | request
//   --------+-----------------------------------------+--------------------------
//   value   | value, value_valid, value_stall         | one integer
//   text    | character, last, text_valid, text_stall | one character, last marks end
//
// the back end takes a request off the queue in its idle state, then emits the sign
// if negative plus one to ten digits, each digit found by a compare against the
// power-of-ten table. the front end registers the next integer meanwhile, the
// queue holds QUEUE_DEPTH requests, and reset clears all control at once.
// text_stall holds the output register and the sign and digit steps; once the
// queue is full and the front end holds an integer, it raises value_stall.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  logic               value_valid,
    output logic               value_stall,
    output logic [7:0]         character,
    output logic               last,
    output logic               text_valid,
    input  logic               text_stall
);

    sitoa_pkg::sitoa_item_t q_wr_item;
    sitoa_pkg::sitoa_item_t q_rd_item;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    logic text_char_legal;

    sitoa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .push        (q_push),
        .item        (q_wr_item),
        .full        (q_full)
    );

    sitoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    sitoa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_rd_item),
        .empty      (q_empty),
        .pop        (q_pop),
        .character  (character),
        .last       (last),
        .text_valid (text_valid),
        .text_stall (text_stall)
    );

    // minus sign or a decimal digit
    assign text_char_legal = (character == sitoa_pkg::CHAR_MINUS)
                           || ((character >= sitoa_pkg::CHAR_ZERO)
                               && (character <= sitoa_pkg::CHAR_ZERO + 8'd9));

    `SITOA_ASSERT_IMP(a_no_push_full, q_push, !q_full)
    `SITOA_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty)
    `SITOA_ASSERT_IMP(a_char_legal, text_valid, text_char_legal)
    `SITOA_ASSERT_IMP(a_minus_not_last, text_valid && (character == sitoa_pkg::CHAR_MINUS), !last)

endmodule

// ===== sim/tb.sv =====
// testbench for the signed integer to decimal ascii unit, checked against a predictor
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic signed [31:0] value;
    logic               value_valid;
    logic               value_stall;
    logic [7:0]         character;
    logic               last;
    logic               text_valid;
    logic               text_stall;

    logic [31:0] pending_values[$];
    text_char_t  expected_text[$];
    logic        value_taken;
    logic        quiet;
    int          send_gap;
    int          stall_left;
    int          long_hold;
    int          mismatches;

    signed_int_to_decimal_ascii_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .character   (character),
        .last        (last),
        .text_valid  (text_valid),
        .text_stall  (text_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decimal text of one integer, sign first, digits most significant first
    function automatic void push_decimal_text(input logic [31:0] bits);
        logic [32:0] mag;
        logic [7:0]  digits[11];
        int          ndig;
        text_char_t  t;
        ndig = 0;
        // magnitude at 33 bits so the most negative value survives
        mag = bits[31] ? (33'd0 - {bits[31], bits}) : {1'b0, bits};
        do
        begin
            digits[ndig] = sitoa_pkg::CHAR_ZERO + 8'(mag % 33'd10);
            ndig++;
            mag = mag / 33'd10;
        end
        while (mag != 33'd0);
        if (bits[31])
        begin
            t.ch   = sitoa_pkg::CHAR_MINUS;
            t.last = 1'b0;
            expected_text.push_back(t);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            t.ch   = digits[k];
            t.last = (k == 0);
            expected_text.push_back(t);
        end
    endfunction

    // mix of full-width words and short numbers of either sign
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int unsigned lim;
        int          ndec;
        if ($urandom_range(0, 2) == 0)
        begin
            v = $urandom;
        end
        else
        begin
            ndec = $urandom_range(1, 9);
            lim  = 1;
            repeat (ndec) lim = lim * 10;
            v = $urandom_range(0, lim - 1);
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        return v;
    endfunction

    task automatic report_mismatch(input text_char_t exp, input text_char_t got,
                                   input bit unexpected);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (unexpected)
                $display("mismatch: unexpected character %h last %b", got.ch, got.last);
            else
                $display("mismatch: expected character %h last %b, got %h last %b",
                         exp.ch, exp.last, got.ch, got.last);
        end
    endtask

    // sender: holds the request until taken, random gaps between requests
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!value_valid || value_taken)
            begin
                if (send_gap > 0 && !quiet)
                begin
                    send_gap = send_gap - 1;
                    value_valid <= 1'b0;
                end
                else if (pending_values.size() > 0)
                begin
                    value       <= pending_values.pop_front();
                    value_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 5);
                end
                else
                begin
                    value_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: long hold when asked, otherwise short random stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold > 0)
            begin
                long_hold = long_hold - 1;
                text_stall <= 1'b1;
            end
            else if (stall_left > 0 && !quiet)
            begin
                stall_left = stall_left - 1;
                text_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                text_stall <= 1'b1;
            end
            else
            begin
                text_stall <= 1'b0;
            end
        end
    end

    // monitor: predict on each taken request, check each taken character
    always @(posedge clk)
    begin
        text_char_t got;
        text_char_t exp;
        if (rst_n)
        begin
            value_taken <= value_valid && !value_stall;
            if (value_valid && !value_stall)
                push_decimal_text(value);
            if (text_valid && !text_stall)
            begin
                got.ch   = character;
                got.last = last;
                if (expected_text.size() == 0)
                begin
                    exp = '0;
                    report_mismatch(exp, got, 1'b1);
                end
                else
                begin
                    exp = expected_text.pop_front();
                    if (got.ch !== exp.ch || got.last !== exp.last)
                        report_mismatch(exp, got, 1'b0);
                end
            end
        end
    end

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_values.size() != 0 || value_valid || expected_text.size() != 0);
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        value       = '0;
        value_valid = 1'b0;
        text_stall  = 1'b0;
        value_taken = 1'b0;
        quiet       = 1'b0;
        send_gap    = 0;
        stall_left  = 0;
        long_hold   = 0;
        mismatches  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero, single digits, decade edges, both extremes, near-extremes
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'd99);
        pending_values.push_back(32'd100);
        pending_values.push_back(-32'sd7);
        pending_values.push_back(32'd12345);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(-32'sd999999999);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'hAAAA_5555);
        pending_values.push_back(32'h5555_AAAA);
        // sender pauses here until every character is back
        wait_for_drain();

        // receiver holds off while requests keep coming, so the input backs up
        @(posedge clk);
        long_hold = 150;
        repeat (30) pending_values.push_back(random_value());
        wait_for_drain();

        repeat (130) pending_values.push_back(random_value());
        wait_for_drain();

        quiet = 1'b1;
        repeat (30) pending_values.push_back(random_value());
        wait_for_drain();

        repeat (30) @(posedge clk);
        if (expected_text.size() != 0)
            mismatches += expected_text.size();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
